// ----- sv/ffa_pkg.sv -----
// shared types and constants of the first-fit arena allocator
`timescale 1ns / 1ps

package ffa_pkg;

	// payload widths of the channels
	localparam int OPCODE_W  = 1;
	localparam int REQ_W     = 21;
	localparam int OFF_W     = 20;
	localparam int STATUS_W  = 2;
	localparam int GRANT_W   = 21;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 21;
	localparam int HDR_W     = 8;

	// allocation grain
	localparam int         GRAIN      = 8;
	localparam logic [2:0] GRAIN_MASK = 3'h7;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_ARENA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd1;
	localparam logic [CFG_DAT_W-1:0] ARENA_RST  = 21'd65536;
	localparam logic [HDR_W-1:0]     HDR_RST    = 8'd56;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		RS_OK        = 2'd0,
		RS_EXHAUSTED = 2'd1,
		RS_BAD_FREE  = 2'd2
	} res_code_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX1,
		RD_JP1,
		RD_JM1
	} rd_sel_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_A_CHK,
		S_A_RD,
		S_A_EVAL,
		S_A_SUCC,
		S_A_SRD,
		S_A_FIT,
		S_RM_CHK,
		S_RM_WR,
		S_IN_CHK,
		S_IN_WR,
		S_IN_FIN,
		S_F_CHK,
		S_F_RD,
		S_F_EVAL,
		S_DONE_OK,
		S_DONE_EXH,
		S_DONE_BAD
	} state_t;

	typedef struct packed {
		logic      rebuild;
		logic      cfg_load;
		logic      item_load;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      cur_load;
		logic      step;
		logic      merge_prev;
		logic      merge_succ;
		logic      sweep_rm;
		logic      cnt_dec;
		logic      ins_start;
		logic      sweep_ins;
		logic      ins_new;
		logic      wr_cur;
		logic      wbusy;
		logic      res_load;
		res_code_t res_code;
	} cmd_t;

	typedef struct packed {
		logic idx_lt_cnt;
		logic idx1_lt_cnt;
		logic j1_lt_cnt;
		logic j_gt_idx1;
		logic cur_busy;
		logic prv_free;
		logic rd_busy;
		logic fits;
		logic split_ok;
		logic off_hit;
		logic req_free;
		logic cfg_known;
	} status_t;

endpackage

// ----- sv/ffa_req_if.sv -----
// request channel: one allocate or free word
`timescale 1ns / 1ps

interface ffa_req_if;
	logic                          valid;
	logic                          ready;
	logic [ffa_pkg::OPCODE_W-1:0]  opcode;
	logic [ffa_pkg::REQ_W-1:0]     request_bytes;
	logic [ffa_pkg::OFF_W-1:0]     block_offset;

	modport source(output valid, opcode, request_bytes, block_offset, input ready);
	modport sink(input valid, opcode, request_bytes, block_offset, output ready);
endinterface

// ----- sv/ffa_rsp_if.sv -----
// response channel: one result word per request
`timescale 1ns / 1ps

interface ffa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ffa_pkg::STATUS_W-1:0]  status;
	logic [ffa_pkg::OFF_W-1:0]     data_offset;
	logic [ffa_pkg::GRANT_W-1:0]   granted_bytes;

	modport source(output valid, status, data_offset, granted_bytes, input ready);
	modport sink(input valid, status, data_offset, granted_bytes, output ready);
endinterface

// ----- sv/ffa_cfg_if.sv -----
// configuration write channel
`timescale 1ns / 1ps

interface ffa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ffa_pkg::CFG_IDX_W-1:0] index;
	logic [ffa_pkg::CFG_DAT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/ffa_ram.sv -----
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps

module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/ffa_datapath.sv -----
// block table, working registers and arithmetic of the allocator
`timescale 1ns / 1ps

module ffa_datapath #(
	parameter int MAX_BLOCKS = 64,
	parameter int ARENA_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffa_pkg::cmd_t                 cmd,
	output ffa_pkg::status_t              st,
	input  logic [ffa_pkg::OPCODE_W-1:0]  req_opcode,
	input  logic [ffa_pkg::REQ_W-1:0]     req_request_bytes,
	input  logic [ffa_pkg::OFF_W-1:0]     req_block_offset,
	input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffa_pkg::CFG_DAT_W-1:0] cfg_data,
	output logic [ffa_pkg::STATUS_W-1:0]  res_status,
	output logic [ffa_pkg::OFF_W-1:0]     res_data_offset,
	output logic [ffa_pkg::GRANT_W-1:0]   res_granted_bytes
);

	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CNTW = $clog2(MAX_BLOCKS + 1);
	localparam int AB   = ARENA_BITS;
	localparam int CW   = ((AB > 22) ? AB : 22) + 2;
	localparam int WW   = 1 + 2 * AB;

	// configuration registers
	logic [ffa_pkg::CFG_DAT_W-1:0] arena_q;
	logic [ffa_pkg::HDR_W-1:0]     hdr_q;

	// walk registers
	logic [CNTW-1:0] cnt_q, idx_q, j_q;
	logic [CW-1:0]   size_q;
	logic [ffa_pkg::OFF_W-1:0] off_q;
	logic [AB-1:0]   cur_start_q, cur_len_q, prv_start_q, prv_len_q;
	logic            cur_busy_q, prv_busy_q;

	// result registers
	logic [ffa_pkg::STATUS_W-1:0] res_status_q;
	logic [ffa_pkg::OFF_W-1:0]    res_off_q;
	logic [ffa_pkg::GRANT_W-1:0]  res_grant_q;

	// table memory
	logic            ram_we;
	logic [IW-1:0]   ram_waddr, ram_raddr;
	logic [WW-1:0]   ram_wdata, ram_rdata;
	logic            r_busy;
	logic [AB-1:0]   r_start, r_len;

	ffa_ram #(.WIDTH(WW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign r_busy  = ram_rdata[WW-1];
	assign r_start = ram_rdata[2*AB-1:AB];
	assign r_len   = ram_rdata[AB-1:0];

	// header size and clamped arena
	logic [ffa_pkg::HDR_W-1:0] h8;
	logic [CW-1:0] h_c, limit_c, arena_c, arena_cl;
	logic [CW-1:0] size_rnd, cur_len_c, cur_data_c;
	logic [CNTW-1:0] idx1, jp1, jm1;

	assign h8       = (hdr_q[7:3] == 5'd0) ? 8'(ffa_pkg::GRAIN) : {hdr_q[7:3], 3'b000};
	assign h_c      = CW'(h8);
	assign limit_c  = CW'(1) << AB;
	assign arena_c  = CW'(arena_q);
	assign arena_cl = (arena_c > limit_c) ? limit_c : arena_c;

	// request rounded up to the grain
	assign size_rnd = ((req_request_bytes[2:0] & ffa_pkg::GRAIN_MASK) != 3'd0)
		? CW'({req_request_bytes[ffa_pkg::REQ_W-1:3], 3'b000}) + CW'(ffa_pkg::GRAIN)
		: CW'(req_request_bytes);

	assign cur_len_c  = CW'(cur_len_q);
	assign cur_data_c = CW'(cur_start_q) + h_c;
	assign idx1       = idx_q + CNTW'(1);
	assign jp1        = j_q + CNTW'(1);
	assign jm1        = j_q - CNTW'(1);

	// status toward the controller
	always_comb begin
		st.idx_lt_cnt  = idx_q < cnt_q;
		st.idx1_lt_cnt = (CNTW+1)'(idx_q) + (CNTW+1)'(1) < (CNTW+1)'(cnt_q);
		st.j1_lt_cnt   = (CNTW+1)'(j_q) + (CNTW+1)'(1) < (CNTW+1)'(cnt_q);
		st.j_gt_idx1   = (CNTW+1)'(j_q) > (CNTW+1)'(idx_q) + (CNTW+1)'(1);
		st.cur_busy    = cur_busy_q;
		st.prv_free    = !prv_busy_q;
		st.rd_busy     = r_busy;
		st.fits        = cur_len_c >= size_q;
		st.split_ok    = (cur_len_c > size_q + h_c + CW'(ffa_pkg::GRAIN))
			&& (cnt_q < CNTW'(MAX_BLOCKS));
		st.off_hit     = cur_data_c == CW'(off_q);
		st.req_free    = req_opcode == ffa_pkg::OP_FREE;
		st.cfg_known   = (cfg_index == ffa_pkg::REG_ARENA) || (cfg_index == ffa_pkg::REG_HEADER);
	end

	// read address select
	always_comb begin
		unique case (cmd.rd_sel)
			ffa_pkg::RD_IDX:  ram_raddr = idx_q[IW-1:0];
			ffa_pkg::RD_IDX1: ram_raddr = idx1[IW-1:0];
			ffa_pkg::RD_JP1:  ram_raddr = jp1[IW-1:0];
			ffa_pkg::RD_JM1:  ram_raddr = jm1[IW-1:0];
			default:          ram_raddr = idx_q[IW-1:0];
		endcase
	end

	// write port select
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = {cmd.wbusy, cur_start_q, cur_len_q};
		priority if (cmd.rebuild) begin
			ram_we    = 1'b1;
			ram_waddr = IW'(0);
			ram_wdata = {1'b0, AB'(0), AB'(arena_cl - h_c)};
		end else if (cmd.sweep_rm || cmd.sweep_ins) begin
			ram_we    = 1'b1;
			ram_waddr = j_q[IW-1:0];
			ram_wdata = ram_rdata;
		end else if (cmd.ins_new) begin
			ram_we    = 1'b1;
			ram_waddr = idx1[IW-1:0];
			ram_wdata = {1'b0, AB'(cur_data_c + size_q), AB'(cur_len_c - size_q - h_c)};
		end else if (cmd.wr_cur) begin
			ram_we    = 1'b1;
		end
	end

	// register updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q      <= ffa_pkg::ARENA_RST;
			hdr_q        <= ffa_pkg::HDR_RST;
			cnt_q        <= '0;
			idx_q        <= '0;
			j_q          <= '0;
			size_q       <= '0;
			off_q        <= '0;
			cur_start_q  <= '0;
			cur_len_q    <= '0;
			cur_busy_q   <= 1'b0;
			prv_start_q  <= '0;
			prv_len_q    <= '0;
			prv_busy_q   <= 1'b1;
			res_status_q <= '0;
			res_off_q    <= '0;
			res_grant_q  <= '0;
		end else begin
			if (cmd.cfg_load) begin
				if (cfg_index == ffa_pkg::REG_ARENA) begin
					arena_q <= cfg_data;
				end
				if (cfg_index == ffa_pkg::REG_HEADER) begin
					hdr_q <= cfg_data[ffa_pkg::HDR_W-1:0];
				end
			end
			if (cmd.rebuild) begin
				cnt_q <= (arena_cl < h_c) ? CNTW'(0) : CNTW'(1);
			end
			if (cmd.item_load) begin
				size_q     <= size_rnd;
				off_q      <= req_block_offset;
				idx_q      <= '0;
				prv_busy_q <= 1'b1;
			end
			if (cmd.cur_load) begin
				cur_start_q <= r_start;
				cur_len_q   <= r_len;
				cur_busy_q  <= r_busy;
			end
			// advance past the current block
			if (cmd.step) begin
				prv_start_q <= cur_start_q;
				prv_len_q   <= cur_len_q;
				prv_busy_q  <= cur_busy_q;
				idx_q       <= idx1;
			end
			// fold the current block into its free predecessor
			if (cmd.merge_prev) begin
				cur_len_q   <= AB'(CW'(prv_len_q) + cur_len_c + h_c);
				cur_start_q <= prv_start_q;
				j_q         <= idx_q;
				idx_q       <= idx_q - CNTW'(1);
			end
			// absorb the free successor
			if (cmd.merge_succ) begin
				cur_len_q <= AB'(cur_len_c + CW'(r_len) + h_c);
				j_q       <= idx1;
			end
			if (cmd.sweep_rm) begin
				j_q <= jp1;
			end
			if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
			if (cmd.ins_start) begin
				j_q <= cnt_q;
			end
			if (cmd.sweep_ins) begin
				j_q <= jm1;
			end
			if (cmd.ins_new) begin
				cnt_q     <= cnt_q + CNTW'(1);
				cur_len_q <= AB'(size_q);
			end
			if (cmd.res_load) begin
				res_status_q <= cmd.res_code;
				if (cmd.res_code == ffa_pkg::RS_OK) begin
					res_off_q   <= cur_data_c[ffa_pkg::OFF_W-1:0];
					res_grant_q <= cur_len_c[ffa_pkg::GRANT_W-1:0];
				end else begin
					res_off_q   <= '0;
					res_grant_q <= '0;
				end
			end
		end
	end

	assign res_status        = res_status_q;
	assign res_data_offset   = res_off_q;
	assign res_granted_bytes = res_grant_q;

endmodule

// ----- sv/ffa_ctrl.sv -----
// sequencer of the allocator walk, table sweeps and result handoff
`timescale 1ns / 1ps

module ffa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  ffa_pkg::status_t st,
	output ffa_pkg::cmd_t    cmd,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	output logic             out_valid,
	input  logic             out_ready
);

	ffa_pkg::state_t state_q, state_d;
	logic            ret_fit_q, ret_fit_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = state_q == ffa_pkg::S_IDLE;
	assign req_ready = (state_q == ffa_pkg::S_IDLE) && !cfg_valid;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d   = state_q;
		ret_fit_d = ret_fit_q;
		unique case (state_q)
			ffa_pkg::S_INIT: state_d = ffa_pkg::S_IDLE;
			ffa_pkg::S_IDLE: begin
				if (cfg_valid) begin
					state_d = st.cfg_known ? ffa_pkg::S_INIT : ffa_pkg::S_IDLE;
				end else if (req_valid) begin
					state_d = st.req_free ? ffa_pkg::S_F_CHK : ffa_pkg::S_A_CHK;
				end
			end
			ffa_pkg::S_A_CHK: state_d = st.idx_lt_cnt ? ffa_pkg::S_A_RD : ffa_pkg::S_DONE_EXH;
			ffa_pkg::S_A_RD:  state_d = ffa_pkg::S_A_EVAL;
			ffa_pkg::S_A_EVAL: begin
				if (st.cur_busy) begin
					state_d = ffa_pkg::S_A_CHK;
				end else if (st.prv_free) begin
					state_d   = ffa_pkg::S_RM_CHK;
					ret_fit_d = 1'b0;
				end else begin
					state_d = ffa_pkg::S_A_SUCC;
				end
			end
			ffa_pkg::S_A_SUCC: state_d = st.idx1_lt_cnt ? ffa_pkg::S_A_SRD : ffa_pkg::S_A_FIT;
			ffa_pkg::S_A_SRD: begin
				if (!st.rd_busy) begin
					state_d   = ffa_pkg::S_RM_CHK;
					ret_fit_d = 1'b1;
				end else begin
					state_d = ffa_pkg::S_A_FIT;
				end
			end
			ffa_pkg::S_A_FIT: begin
				if (st.fits && st.split_ok) begin
					state_d = ffa_pkg::S_IN_CHK;
				end else if (st.fits) begin
					state_d = ffa_pkg::S_DONE_OK;
				end else begin
					state_d = ffa_pkg::S_A_CHK;
				end
			end
			ffa_pkg::S_RM_CHK: begin
				if (st.j1_lt_cnt) begin
					state_d = ffa_pkg::S_RM_WR;
				end else begin
					state_d = ret_fit_q ? ffa_pkg::S_A_FIT : ffa_pkg::S_A_SUCC;
				end
			end
			ffa_pkg::S_RM_WR:  state_d = ffa_pkg::S_RM_CHK;
			ffa_pkg::S_IN_CHK: state_d = st.j_gt_idx1 ? ffa_pkg::S_IN_WR : ffa_pkg::S_IN_FIN;
			ffa_pkg::S_IN_WR:  state_d = ffa_pkg::S_IN_CHK;
			ffa_pkg::S_IN_FIN: state_d = ffa_pkg::S_DONE_OK;
			ffa_pkg::S_F_CHK:  state_d = st.idx_lt_cnt ? ffa_pkg::S_F_RD : ffa_pkg::S_DONE_BAD;
			ffa_pkg::S_F_RD:   state_d = ffa_pkg::S_F_EVAL;
			ffa_pkg::S_F_EVAL: begin
				if (st.off_hit) begin
					state_d = st.cur_busy ? ffa_pkg::S_DONE_OK : ffa_pkg::S_DONE_BAD;
				end else begin
					state_d = ffa_pkg::S_F_CHK;
				end
			end
			ffa_pkg::S_DONE_OK, ffa_pkg::S_DONE_EXH, ffa_pkg::S_DONE_BAD: begin
				if (out_free) begin
					state_d = ffa_pkg::S_IDLE;
				end
			end
			default: state_d = ffa_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = ffa_pkg::RD_IDX;
		cmd.res_code = ffa_pkg::RS_OK;
		unique case (state_q)
			ffa_pkg::S_INIT: cmd.rebuild = 1'b1;
			ffa_pkg::S_IDLE: begin
				if (cfg_valid) begin
					cmd.cfg_load = 1'b1;
				end else if (req_valid) begin
					cmd.item_load = 1'b1;
				end
			end
			ffa_pkg::S_A_CHK, ffa_pkg::S_F_CHK: begin
				cmd.rd_en  = st.idx_lt_cnt;
				cmd.rd_sel = ffa_pkg::RD_IDX;
			end
			ffa_pkg::S_A_RD, ffa_pkg::S_F_RD: cmd.cur_load = 1'b1;
			ffa_pkg::S_A_EVAL: begin
				if (st.cur_busy) begin
					cmd.step = 1'b1;
				end else if (st.prv_free) begin
					cmd.merge_prev = 1'b1;
				end
			end
			ffa_pkg::S_A_SUCC: begin
				cmd.rd_en  = st.idx1_lt_cnt;
				cmd.rd_sel = ffa_pkg::RD_IDX1;
			end
			ffa_pkg::S_A_SRD: cmd.merge_succ = !st.rd_busy;
			ffa_pkg::S_A_FIT: begin
				if (st.fits && st.split_ok) begin
					cmd.ins_start = 1'b1;
				end else if (st.fits) begin
					cmd.wr_cur = 1'b1;
					cmd.wbusy  = 1'b1;
				end else begin
					cmd.wr_cur = 1'b1;
					cmd.step   = 1'b1;
				end
			end
			ffa_pkg::S_RM_CHK: begin
				cmd.rd_en   = st.j1_lt_cnt;
				cmd.rd_sel  = ffa_pkg::RD_JP1;
				cmd.cnt_dec = !st.j1_lt_cnt;
			end
			ffa_pkg::S_RM_WR: cmd.sweep_rm = 1'b1;
			ffa_pkg::S_IN_CHK: begin
				cmd.rd_en   = st.j_gt_idx1;
				cmd.rd_sel  = ffa_pkg::RD_JM1;
				cmd.ins_new = !st.j_gt_idx1;
			end
			ffa_pkg::S_IN_WR: cmd.sweep_ins = 1'b1;
			ffa_pkg::S_IN_FIN: begin
				cmd.wr_cur = 1'b1;
				cmd.wbusy  = 1'b1;
			end
			ffa_pkg::S_F_EVAL: begin
				if (st.off_hit) begin
					cmd.wr_cur = st.cur_busy;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ffa_pkg::S_DONE_OK: begin
				cmd.res_load = out_free;
				cmd.res_code = ffa_pkg::RS_OK;
			end
			ffa_pkg::S_DONE_EXH: begin
				cmd.res_load = out_free;
				cmd.res_code = ffa_pkg::RS_EXHAUSTED;
			end
			ffa_pkg::S_DONE_BAD: begin
				cmd.res_load = out_free;
				cmd.res_code = ffa_pkg::RS_BAD_FREE;
			end
			default: cmd.rd_sel = ffa_pkg::RD_IDX;
		endcase
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffa_pkg::S_INIT;
			ret_fit_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_fit_q <= ret_fit_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/first_fit_arena_allocator_core.sv -----
// top level of the first-fit arena allocator with lazy coalescing
// usage:
//   req carries one word per operation: opcode 0 allocates request_bytes
//   (rounded up to 8), opcode 1 frees the block whose data starts at
//   block_offset. rsp returns one word per request: status, data_offset and
//   granted_bytes. cfg writes arena_size (index 0) or header_size (index 1);
//   either write rebuilds the arena as one free block (none if arena < header).
// timing:
//   one request is worked at a time. a free scans the table entries in
//   order. an allocate walks the entries, merging each free entry with
//   its free neighbours, and moves the later table entries when a merge
//   removes one or a split inserts one.
// reset:
//   registers return to arena 65536 and header 56; after the init state that
//   follows reset the table holds one free block and req and cfg become ready.
// stalls:
//   a result waits in the output register while rsp.ready is low; the next
//   request is still taken and worked, and only its result handoff waits.
`timescale 1ns / 1ps

module first_fit_arena_allocator_core #(
	parameter int MAX_BLOCKS = 64,
	parameter int ARENA_BITS = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	ffa_req_if.sink   req,
	ffa_rsp_if.source rsp,
	ffa_cfg_if.sink   cfg
);

	ffa_pkg::cmd_t    cmd;
	ffa_pkg::status_t st;

	// sequencer
	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.st        (st),
		.cmd       (cmd),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready)
	);

	// table and arithmetic
	ffa_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ARENA_BITS (ARENA_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.req_opcode        (req.opcode),
		.req_request_bytes (req.request_bytes),
		.req_block_offset  (req.block_offset),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.res_status        (rsp.status),
		.res_data_offset   (rsp.data_offset),
		.res_granted_bytes (rsp.granted_bytes)
	);

endmodule
